// ----- rtl/core/rre_pkg.sv -----
// Shared types and constants for the row run-length RGB encoder.
package rre_pkg;

    localparam int LenW       = 16;
    localparam int ColourW    = 24;
    localparam int CfgDataW   = 16;
    localparam int CfgIdxW    = 1;
    localparam int QueueDepth = 4;

    localparam logic [CfgIdxW-1:0] RegRowWidth = 1'd0;
    localparam logic [CfgIdxW-1:0] RegRleMode  = 1'd1;

    // Up to two records caused by one pixel: a closed run, then the pixel/row record.
    typedef struct packed {
        logic               has_a;
        logic [LenW-1:0]    a_len;
        logic [ColourW-1:0] a_colour;
        logic               has_b;
        logic [LenW-1:0]    b_len;
        logic [ColourW-1:0] b_colour;
        logic               b_row_end;
    } t_cmd;

endpackage

// ----- rtl/core/row_rle_rgb_encoder.sv -----
// Top level of the row run-length RGB encoder.
// Path: a record is written into the command queue at the edge that accepts the pixel
// causing it, then loaded into the output register; the second record of a pair follows.
// Throughput: one pixel per cycle while the command queue is not full; a pixel causing
// two records holds the output register for both in turn, absorbed by the command queue.
// Reset: synchronous active low; row width 1, run-length mode on, no run open.
module row_rle_rgb_encoder import rre_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,  // red, green, blue
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,  // run_length, run_red, run_green, run_blue
    output logic                m_axis_tlast,  // row_end
    output logic                m_axis_tuser   // last
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    t_cmd               cmd_in;
    t_cmd               cmd_out;
    logic [ColourW-1:0] pixel;
    logic [LenW-1:0]    len;
    logic [ColourW-1:0] colour;

    assign pixel = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    rre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (pixel),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd_in)
    );

    rre_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    rre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_cmd     (cmd_out),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_len     (len),
        .o_colour  (colour),
        .o_row_end (m_axis_tlast),
        .o_last    (m_axis_tuser)
    );

    assign m_axis_tdata = {colour[7:0], colour[15:8], colour[23:16], len};

endmodule

// ----- rtl/core/rre_front.sv -----
// Front end: config registers, pixel acceptance, run tracking and command build.
module rre_front import rre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ColourW-1:0]  i_pixel,
    input  logic                i_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic [LenW-1:0]    r_row_width;
    logic               r_rle_mode;
    logic [LenW-1:0]    r_column, n_column;
    logic [LenW-1:0]    r_run, n_run;
    logic [ColourW-1:0] r_held, n_held;
    logic [LenW-1:0]    width;
    logic               ends_row;
    logic               accept;
    t_cmd               cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        width    = (r_row_width == '0) ? LenW'(1) : r_row_width;
        ends_row = ({1'b0, r_column} + (LenW+1)'(1)) >= {1'b0, width};
        cmd      = '0;
        n_run    = r_run;
        n_held   = r_held;
        if (!r_rle_mode) begin
            if (r_run != '0) begin
                cmd.has_a    = 1'b1;
                cmd.a_len    = r_run;
                cmd.a_colour = r_held;
                n_run        = '0;
            end
            cmd.has_b     = 1'b1;
            cmd.b_len     = LenW'(1);
            cmd.b_colour  = i_pixel;
            cmd.b_row_end = ends_row;
        end else begin
            if (r_run == '0) begin
                n_held = i_pixel;
                n_run  = LenW'(1);
            end else if (i_pixel == r_held) begin
                if (r_run != '1) begin
                    n_run = r_run + LenW'(1);
                end
            end else begin
                cmd.has_a    = 1'b1;
                cmd.a_len    = r_run;
                cmd.a_colour = r_held;
                n_held       = i_pixel;
                n_run        = LenW'(1);
            end
            if (ends_row) begin
                cmd.has_b     = 1'b1;
                cmd.b_len     = n_run;
                cmd.b_colour  = n_held;
                cmd.b_row_end = 1'b1;
                n_run         = '0;
            end
        end
        n_column = ends_row ? '0 : (r_column + LenW'(1));
    end

    assign o_push = accept && (cmd.has_a || cmd.has_b);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= LenW'(1);
            r_rle_mode  <= 1'b1;
            r_column    <= '0;
            r_run       <= '0;
            r_held      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegRowWidth: r_row_width <= i_cfg_data;
                    RegRleMode:  r_rle_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_column <= n_column;
                r_run    <= n_run;
                r_held   <= n_held;
            end
        end
    end

endmodule

// ----- rtl/core/rre_queue.sv -----
// Short command queue between front and back ends.
module rre_queue import rre_pkg::*; #(
    parameter int DEPTH = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/rre_back.sv -----
// Back end: expands queued commands into records in the output register.
module rre_back import rre_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LenW-1:0]       o_len,
    output logic [ColourW-1:0]    o_colour,
    output logic                  o_row_end,
    output logic                  o_last
);

    logic               r_valid;
    logic               r_phase_b;
    logic [LenW-1:0]    r_len;
    logic [ColourW-1:0] r_colour;
    logic               r_row_end;
    logic               r_last;
    logic               load;
    logic               emit_a;

    assign load   = (!r_valid || i_ready) && !i_empty;
    assign emit_a = i_cmd.has_a && !r_phase_b;
    assign o_pop  = load && !(emit_a && i_cmd.has_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_phase_b <= 1'b0;
        end else begin
            if (load) begin
                r_valid   <= 1'b1;
                r_phase_b <= emit_a && i_cmd.has_b;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_a) begin
                r_len     <= i_cmd.a_len;
                r_colour  <= i_cmd.a_colour;
                r_row_end <= 1'b0;
                r_last    <= !i_cmd.has_b;
            end else begin
                r_len     <= i_cmd.b_len;
                r_colour  <= i_cmd.b_colour;
                r_row_end <= i_cmd.b_row_end;
                r_last    <= 1'b1;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_len     = r_len;
    assign o_colour  = r_colour;
    assign o_row_end = r_row_end;
    assign o_last    = r_last;

endmodule
